// ===== src/gssd_pkg.sv =====
// Shared types and constants of the gimbal sine drive.
`default_nettype none

package gssd_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_FROZEN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_ROLL_LIMIT   = 2'd0,
    REG_PITCH_LIMIT  = 2'd1,
    REG_MODE         = 2'd2,
    REG_FROZEN_POWER = 2'd3
  } cfg_reg_t;

  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = 8;
  localparam int PHASES      = 3;
  localparam int DRIVE_W     = 16;
  localparam int LIMIT_W     = 15;
  localparam int LEVEL_W     = 5;
  localparam int DUTY_W      = 8;
  localparam int LEVEL_SHIFT = 4;

  localparam logic [TABLE_AW-1:0] PHASE_OFFSET [PHASES] = '{8'd0, 8'd85, 8'd170};

endpackage

`default_nettype wire

// ===== src/gimbal_slew_limited_sine_drive.sv =====
// Top level of the two-axis slew-limited sinusoidal gimbal drive.
`default_nettype none

// Takes one item per clock while no result waits on m_tready; a sample passes the
// input register, slew limit with the registered sine table reads, then scaling
// into the output register. Each axis keeps three copies of its sine table,
// one per phase, so the three phase reads of a sample happen in the same cycle; a
// table load writes all copies of its axis. Tick and load items give no result.
// The whole pipeline holds while a result waits on m_tready.
module gimbal_slew_limited_sine_drive
  import gssd_pkg::*;
#(
  parameter int FULL_POWER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // roll_demand[15:0], pitch_demand[31:16], table_axis[32], table_index[40:33],
  // table_value[48:41], zero fill[55:49]
  input  wire logic [55:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // roll_drive[15:0], pitch_drive[31:16], speed_limited[32], roll_phase_a[40:33],
  // roll_phase_b[48:41], roll_phase_c[56:49], pitch_phase_a[64:57],
  // pitch_phase_b[72:65], pitch_phase_c[80:73], zero fill[87:81]
  output logic [87:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(FULL_POWER);

  // configuration
  logic [LIMIT_W-1:0] roll_limit;
  logic [LIMIT_W-1:0] pitch_limit;
  mode_t              mode;
  logic [LEVEL_W-1:0] frozen_power;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_limit   <= '1;
      pitch_limit  <= '1;
      mode         <= MODE_OFF;
      frozen_power <= LEVEL_W'(8);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROLL_LIMIT:   roll_limit   <= cfg_data;
        REG_PITCH_LIMIT:  pitch_limit  <= cfg_data;
        REG_MODE:         mode         <= mode_t'(cfg_data[1:0]);
        REG_FROZEN_POWER: frozen_power <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // input register
  logic                a_valid;
  cmd_t                a_cmd;
  logic [DRIVE_W-1:0]  a_roll;
  logic [DRIVE_W-1:0]  a_pitch;
  logic                a_axis;
  logic [TABLE_AW-1:0] a_index;
  logic [DUTY_W-1:0]   a_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      a_cmd   <= cmd_t'(s_tuser);
      a_roll  <= s_tdata[15:0];
      a_pitch <= s_tdata[31:16];
      a_axis  <= s_tdata[32];
      a_index <= s_tdata[40:33];
      a_value <= s_tdata[48:41];
    end
  end

  logic a_sample, a_tick, a_load;
  assign a_sample = a_valid && (a_cmd == CMD_SAMPLE);
  assign a_tick   = a_valid && (a_cmd == CMD_TICK);
  assign a_load   = a_valid && (a_cmd == CMD_LOAD);

  // returns {clipped, drive}
  function automatic logic [DRIVE_W:0] slew(input logic [DRIVE_W-1:0] demand,
                                            input logic [DRIVE_W-1:0] last,
                                            input logic [LIMIT_W-1:0] lim);
    logic [DRIVE_W-1:0] delta;
    logic signed [DRIVE_W:0] d;
    logic signed [DRIVE_W:0] l;
    logic [DRIVE_W:0] res;
    delta = demand - last;
    d = signed'({delta[DRIVE_W-1], delta});
    l = signed'({2'b00, lim});
    if (d > l) begin
      res = {1'b1, last + {1'b0, lim}};
    end else if (d < -l) begin
      res = {1'b1, last - {1'b0, lim}};
    end else begin
      res = {1'b0, demand};
    end
    return res;
  endfunction

  logic [DRIVE_W-1:0] last_roll, last_pitch;
  logic [DRIVE_W-1:0] roll_next, pitch_next;
  logic               roll_clip, pitch_clip;

  assign {roll_clip, roll_next}   = slew(a_roll, last_roll, roll_limit);
  assign {pitch_clip, pitch_next} = slew(a_pitch, last_pitch, pitch_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_roll  <= '0;
      last_pitch <= '0;
    end else if (advance && a_sample) begin
      last_roll  <= roll_next;
      last_pitch <= pitch_next;
    end
  end

  // soft-start level
  logic [LEVEL_W-1:0] level, level_next, target;

  assign target = (frozen_power > FULL_LEVEL) ? FULL_LEVEL : frozen_power;

  always_comb begin
    level_next = level;
    case (mode)
      MODE_OFF: begin
        if (level != '0) level_next = level - 1'b1;
      end
      MODE_RUN: begin
        if (level < FULL_LEVEL) level_next = level + 1'b1;
      end
      MODE_FROZEN: begin
        if (level < target) level_next = level + 1'b1;
        else if (level > target) level_next = level - 1'b1;
      end
      default: level_next = level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (advance && a_tick) begin
      level <= level_next;
    end
  end

  // sine tables, one copy per phase and axis
  logic [DUTY_W-1:0] roll_rd  [PHASES];
  logic [DUTY_W-1:0] pitch_rd [PHASES];

  for (genvar k = 0; k < PHASES; k++) begin : g_phase
    logic [DUTY_W-1:0]   roll_mem  [TABLE_DEPTH];
    logic [DUTY_W-1:0]   pitch_mem [TABLE_DEPTH];
    logic [TABLE_AW-1:0] roll_addr, pitch_addr;

    assign roll_addr  = roll_next[TABLE_AW-1:0] + PHASE_OFFSET[k];
    assign pitch_addr = pitch_next[TABLE_AW-1:0] + PHASE_OFFSET[k];

    always_ff @(posedge clk) begin
      if (advance && a_load && a_axis) begin
        roll_mem[a_index] <= a_value;
      end
      if (advance) begin
        roll_rd[k] <= roll_mem[roll_addr];
      end
    end

    always_ff @(posedge clk) begin
      if (advance && a_load && !a_axis) begin
        pitch_mem[a_index] <= a_value;
      end
      if (advance) begin
        pitch_rd[k] <= pitch_mem[pitch_addr];
      end
    end
  end

  // slew stage
  logic               b_valid;
  logic [DRIVE_W-1:0] b_roll, b_pitch;
  logic               b_clip;
  logic [LEVEL_W-1:0] b_level;
  logic               b_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_sample) begin
      b_roll  <= roll_next;
      b_pitch <= pitch_next;
      b_clip  <= roll_clip || pitch_clip;
      b_level <= level;
      b_hold  <= (mode == MODE_FROZEN);
    end
  end

  function automatic logic [DUTY_W-1:0] scale(input logic [DUTY_W-1:0] v,
                                              input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W+LEVEL_W-1:0] p;
    logic [DUTY_W+LEVEL_W-LEVEL_SHIFT-1:0] s;
    p = {{LEVEL_W{1'b0}}, v} * {{DUTY_W{1'b0}}, lvl};
    s = p[DUTY_W+LEVEL_W-1:LEVEL_SHIFT];
    return (s > {{(LEVEL_W-LEVEL_SHIFT){1'b0}}, {DUTY_W{1'b1}}}) ? {DUTY_W{1'b1}}
                                                               : s[DUTY_W-1:0];
  endfunction

  // output register; duties hold across frozen samples
  logic [DRIVE_W-1:0] out_roll, out_pitch;
  logic               out_clip;
  logic [DUTY_W-1:0]  duty [2*PHASES];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      for (int i = 0; i < 2*PHASES; i++) duty[i] <= '0;
    end else if (advance) begin
      m_tvalid <= b_valid;
      if (b_valid && !b_hold) begin
        for (int k = 0; k < PHASES; k++) begin
          duty[k]        <= scale(roll_rd[k], b_level);
          duty[PHASES+k] <= scale(pitch_rd[k], b_level);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid) begin
      out_roll  <= b_roll;
      out_pitch <= b_pitch;
      out_clip  <= b_clip;
    end
  end

  assign m_tdata = {7'b0, duty[5], duty[4], duty[3], duty[2], duty[1], duty[0],
                    out_clip, out_pitch, out_roll};

endmodule

`default_nettype wire

// ===== src/gssd_checker.sv =====
// Port-level assertions for the gimbal sine drive, bound to the top level.
`default_nettype none

module gssd_checker
  import gssd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [87:0] m_tdata
);

  // samples accepted whose result has not left yet
  logic [1:0] owed;
  logic       sample_in;
  logic       result_out;

  assign sample_in  = s_tvalid && s_tready && (s_tuser == CMD_SAMPLE);
  assign result_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else if (sample_in && !result_out) begin
      owed <= owed + 2'd1;
    end else if (!sample_in && result_out) begin
      owed <= owed - 2'd1;
    end
  end

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // take input exactly when the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // every result has an accepted sample item behind it
  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (owed != 2'd0))
    else $error("result without a matching sample item");

endmodule

bind gimbal_slew_limited_sine_drive gssd_checker u_gssd_checker (.*);

`default_nettype wire

// ===== tb/sv/sine_drive_checker.sv =====
// Checker for the gimbal sine drive: follows accepted items, predicts results and compares them.
`timescale 1ns / 100ps

module sine_drive_checker
  import gssd_pkg::*;
#(
  parameter int FULL_POWER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [55:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [87:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  output int               outstanding,
  output int               mismatches,
  output int               samples_checked,
  output int               samples_clipped
);

  localparam logic [7:0] PHASE_B_STEP = 8'd85;
  localparam logic [7:0] PHASE_C_STEP = 8'd170;

  // roll is in the lowest bits, same order as m_tdata
  typedef struct packed {
    logic [7:0]  pitch_c;
    logic [7:0]  pitch_b;
    logic [7:0]  pitch_a;
    logic [7:0]  roll_c;
    logic [7:0]  roll_b;
    logic [7:0]  roll_a;
    logic        clip;
    logic [15:0] pitch;
    logic [15:0] roll;
  } drive_result_t;

  drive_result_t pending_drives[$];

  logic [14:0] roll_limit;
  logic [14:0] pitch_limit;
  logic [1:0]  drive_mode;
  logic [4:0]  hold_power;
  logic [15:0] prev_roll;
  logic [15:0] prev_pitch;
  logic [4:0]  level;
  logic [7:0]  duty [6];
  logic [7:0]  roll_tab [256];
  logic [7:0]  pitch_tab [256];

  initial begin
    outstanding = 0;
    mismatches = 0;
    samples_checked = 0;
    samples_clipped = 0;
  end

  function automatic logic [15:0] slew_step(input logic [15:0] demand, input logic [15:0] prev,
                                            input logic [14:0] lim, output logic clipped);
    logic [15:0] diff;
    int d;
    diff = demand - prev;
    d = $signed(diff);
    clipped = 1'b0;
    if (d > int'(lim)) begin
      clipped = 1'b1;
      return prev + {1'b0, lim};
    end
    if (d < -int'(lim)) begin
      clipped = 1'b1;
      return prev - {1'b0, lim};
    end
    return demand;
  endfunction

  function automatic logic [7:0] scale_duty(input logic [7:0] entry, input logic [4:0] lvl);
    logic [12:0] prod;
    prod = entry * lvl;
    prod = prod >> LEVEL_SHIFT;
    return (prod > 13'd255) ? 8'hFF : prod[7:0];
  endfunction

  function automatic string describe(input drive_result_t r);
    return $sformatf("roll %0d pitch %0d clip %0b roll abc %0d/%0d/%0d pitch abc %0d/%0d/%0d",
                     $signed(r.roll), $signed(r.pitch), r.clip, r.roll_a, r.roll_b, r.roll_c,
                     r.pitch_a, r.pitch_b, r.pitch_c);
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t got;
    drive_result_t want;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic clip_r;
    logic clip_p;
    logic [7:0] pos;
    logic [7:0] ib;
    logic [7:0] ic;
    logic [4:0] target;
    if (rst) begin
      roll_limit = 15'h7FFF;
      pitch_limit = 15'h7FFF;
      drive_mode = MODE_OFF;
      hold_power = 5'd8;
      prev_roll = '0;
      prev_pitch = '0;
      level = '0;
      foreach (duty[i]) duty[i] = '0;
      pending_drives.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROLL_LIMIT:   roll_limit = cfg_data;
          REG_PITCH_LIMIT:  pitch_limit = cfg_data;
          REG_MODE:         drive_mode = cfg_data[1:0];
          REG_FROZEN_POWER: hold_power = cfg_data[4:0];
          default: ;
        endcase
      end

      // compare first, so an unexpected result is never matched against this edge's item
      if (m_tvalid && m_tready) begin
        got = drive_result_t'(m_tdata[80:0]);
        if (pending_drives.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected drive result at %0t: %s", $time, describe(got));
          mismatches++;
        end else begin
          want = pending_drives.pop_front();
          samples_checked++;
          if (want.clip)
            samples_clipped++;
          if (got.roll != want.roll || got.pitch != want.pitch || got.clip != want.clip ||
              got.roll_a != want.roll_a || got.roll_b != want.roll_b ||
              got.roll_c != want.roll_c || got.pitch_a != want.pitch_a ||
              got.pitch_b != want.pitch_b || got.pitch_c != want.pitch_c) begin
            if (mismatches < 10) begin
              $display("drive mismatch at %0t", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        case (s_tuser)
          CMD_SAMPLE: begin
            roll = slew_step(s_tdata[15:0], prev_roll, roll_limit, clip_r);
            pitch = slew_step(s_tdata[31:16], prev_pitch, pitch_limit, clip_p);
            prev_roll = roll;
            prev_pitch = pitch;
            if (drive_mode != MODE_FROZEN) begin
              pos = roll[7:0];
              ib = pos + PHASE_B_STEP;
              ic = pos + PHASE_C_STEP;
              duty[0] = scale_duty(roll_tab[pos], level);
              duty[1] = scale_duty(roll_tab[ib], level);
              duty[2] = scale_duty(roll_tab[ic], level);
              pos = pitch[7:0];
              ib = pos + PHASE_B_STEP;
              ic = pos + PHASE_C_STEP;
              duty[3] = scale_duty(pitch_tab[pos], level);
              duty[4] = scale_duty(pitch_tab[ib], level);
              duty[5] = scale_duty(pitch_tab[ic], level);
            end
            want.roll = roll;
            want.pitch = pitch;
            want.clip = clip_r | clip_p;
            want.roll_a = duty[0];
            want.roll_b = duty[1];
            want.roll_c = duty[2];
            want.pitch_a = duty[3];
            want.pitch_b = duty[4];
            want.pitch_c = duty[5];
            pending_drives.push_back(want);
          end
          CMD_TICK: begin
            case (drive_mode)
              MODE_OFF: begin
                if (level != 0)
                  level = level - 1'b1;
              end
              MODE_RUN: begin
                if (level < FULL_POWER)
                  level = level + 1'b1;
              end
              MODE_FROZEN: begin
                target = (hold_power > FULL_POWER) ? 5'(FULL_POWER) : hold_power;
                if (level < target)
                  level = level + 1'b1;
                else if (level > target)
                  level = level - 1'b1;
              end
              default: ;
            endcase
          end
          CMD_LOAD: begin
            if (s_tdata[32])
              roll_tab[s_tdata[40:33]] = s_tdata[48:41];
            else
              pitch_tab[s_tdata[40:33]] = s_tdata[48:41];
          end
          default: ;
        endcase
      end
    end
    outstanding <= pending_drives.size();
  end

endmodule

// ===== tb/sv/tb_gimbal_slew_limited_sine_drive.sv =====
// Testbench top for the gimbal sine drive: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_gimbal_slew_limited_sine_drive;
  import gssd_pkg::*;

  localparam int FULL_POWER    = 16;
  localparam int RANDOM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // roll is in the lowest bits, same order as s_tdata
  typedef struct packed {
    logic [6:0]  fill;
    logic [7:0]  value;
    logic [7:0]  index;
    logic        axis;
    logic [15:0] pitch;
    logic [15:0] roll;
  } drive_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  int outstanding;
  int mismatches;
  int samples_checked;
  int samples_clipped;

  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_done;
  int          hold_left;
  int          rx_count;
  int          ticks_sent = 0;
  int          loads_sent = 0;
  int          ignored_sent = 0;
  int          settings_used = 0;
  logic [15:0] roll_dem = '0;
  logic [15:0] pitch_dem = '0;

  gimbal_slew_limited_sine_drive #(
    .FULL_POWER(FULL_POWER)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sine_drive_checker #(
    .FULL_POWER(FULL_POWER)
  ) drive_chk (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .outstanding(outstanding),
    .mismatches(mismatches),
    .samples_checked(samples_checked),
    .samples_clipped(samples_clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: rotate through stall patterns, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_count <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rx_count <= rx_count + 1;
      case (rx_count[10:9])
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_tready <= ((rx_count % 7) < 3);
        default: m_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("gimbal_slew_limited_sine_drive regression: fail");
    $finish;
  end

  function automatic drive_item_t noise_item();
    drive_item_t it;
    it = 56'({$urandom, $urandom});
    it.fill = '0;
    return it;
  endfunction

  function automatic drive_item_t sample_item(input logic [15:0] roll, input logic [15:0] pitch);
    drive_item_t it;
    it = noise_item();
    it.roll = roll;
    it.pitch = pitch;
    return it;
  endfunction

  function automatic logic [15:0] pick_demand(input logic [15:0] prev);
    logic [15:0] step;
    step = 16'($urandom_range(0, 600));
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return prev + step - 16'd300;
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'd1;
      3:       return 15'($urandom_range(0, 255));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 5))
      0, 1, 2: return MODE_RUN;
      3:       return MODE_FROZEN;
      4:       return MODE_OFF;
      default: return MODE_UNUSED;
    endcase
  endfunction

  function automatic logic [4:0] pick_power();
    case ($urandom_range(0, 4))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // offer one item in bursts; valid stays high into the next item
  task automatic send_item(input logic [1:0] cmd, input drive_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= it;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  // drain all results, then let the pipeline empty of tick and load items
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [14:0] roll_lim, input logic [14:0] pitch_lim,
                          input logic [1:0] mode, input logic [4:0] power);
    settle();
    write_reg(REG_ROLL_LIMIT, roll_lim);
    write_reg(REG_PITCH_LIMIT, pitch_lim);
    write_reg(REG_MODE, {13'd0, mode});
    write_reg(REG_FROZEN_POWER, {10'd0, power});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random(inout int useful);
    drive_item_t it;
    int r;
    it = noise_item();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      roll_dem = pick_demand(roll_dem);
      pitch_dem = pick_demand(pitch_dem);
      it.roll = roll_dem;
      it.pitch = pitch_dem;
      send_item(CMD_SAMPLE, it);
      useful++;
    end else if (r < 80) begin
      send_item(CMD_TICK, it);
      ticks_sent++;
      useful++;
    end else if (r < 96) begin
      send_item(CMD_LOAD, it);
      loads_sent++;
      useful++;
    end else begin
      send_item(CMD_UNUSED, it);
      ignored_sent++;
    end
  endtask

  initial begin
    drive_item_t it;
    int useful;
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both tables so no sample ever reads an unwritten entry
    for (int axis = 0; axis < 2; axis++) begin
      for (int idx = 0; idx < TABLE_DEPTH; idx++) begin
        it = noise_item();
        it.axis = axis[0];
        it.index = idx[7:0];
        it.value = (idx == 0) ? 8'hFF : (idx == 1) ? 8'h00 : 8'($urandom_range(0, 255));
        send_item(CMD_LOAD, it);
        loads_sent++;
      end
    end

    // reset settings: mode off, level at zero
    send_item(CMD_SAMPLE, sample_item(16'h0000, 16'h0000));
    send_item(CMD_TICK, noise_item());
    ticks_sent++;
    send_item(CMD_UNUSED, noise_item());
    ignored_sent++;

    // running, roll locked by a zero limit, pitch at the widest limit
    set_regs(15'd0, 15'h7FFF, MODE_RUN, 5'd31);
    repeat (3) begin
      send_item(CMD_TICK, noise_item());
      ticks_sent++;
    end
    send_item(CMD_SAMPLE, sample_item(16'h7FFF, 16'h8000));
    send_item(CMD_SAMPLE, sample_item(16'h8000, 16'h7FFF));
    send_item(CMD_SAMPLE, sample_item(16'h0000, 16'hFFFF));
    it = noise_item();
    it.axis = 1'b1;
    it.index = 8'd0;
    it.value = 8'hFF;
    send_item(CMD_LOAD, it);
    loads_sent++;

    // frozen with a target above full power: phases hold, level climbs
    set_regs(15'd1, 15'd1, MODE_FROZEN, 5'd31);
    repeat (2) begin
      send_item(CMD_TICK, noise_item());
      ticks_sent++;
    end
    send_item(CMD_SAMPLE, sample_item(16'd5, 16'hFFFB));
    send_item(CMD_SAMPLE, sample_item(16'd1, 16'hFFFF));

    // undefined mode: ticks leave the level, samples commutate
    set_regs(15'd300, 15'd300, MODE_UNUSED, 5'd0);
    send_item(CMD_TICK, noise_item());
    ticks_sent++;
    send_item(CMD_SAMPLE, sample_item(16'd100, 16'd100));

    // frozen toward zero, then off
    set_regs(15'h7FFF, 15'h7FFF, MODE_FROZEN, 5'd0);
    repeat (2) begin
      send_item(CMD_TICK, noise_item());
      ticks_sent++;
    end
    set_regs(15'h7FFF, 15'h7FFF, MODE_OFF, 5'd16);
    send_item(CMD_TICK, noise_item());
    ticks_sent++;
    send_item(CMD_SAMPLE, sample_item(16'h1234, 16'hEDCC));

    useful = 0;
    phase = 0;
    while (useful < RANDOM_ITEMS) begin
      set_regs(pick_limit(), pick_limit(), pick_mode(), pick_power());
      gaps_on = (phase % 3) != 1;
      // back-pressure: receiver holds off while items keep coming
      if (phase == 2) begin
        hold_req <= 1'b1;
        gaps_on = 1'b0;
      end
      repeat ($urandom_range(80, 160)) send_random(useful);
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d checked samples (%0d speed-limited), %0d ticks, %0d table writes,",
             samples_checked, samples_clipped, ticks_sent, loads_sent);
    $display("%0d ignored items, across %0d register settings", ignored_sent, settings_used);
    if (mismatches == 0) begin
      $display("gimbal_slew_limited_sine_drive regression: pass");
    end else begin
      $display("gimbal_slew_limited_sine_drive regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gssd_pkg.sv
src/gimbal_slew_limited_sine_drive.sv
src/gssd_checker.sv
tb/sv/sine_drive_checker.sv
tb/sv/tb_gimbal_slew_limited_sine_drive.sv
